/* hw/rtl/mdct_pkg.sv */
// ----------------------------------------------------------------------------
// mdct_pkg
// Shared widths, constants and the elaboration-time cosine table builder for
// the direct-form MDCT/IMDCT engine.
// ----------------------------------------------------------------------------
package mdct_pkg;

  localparam int HALF_SIZE_DEF = 32;

  localparam int IN_W      = 24;
  localparam int OUT_W     = 32;
  localparam int IDX_OUT_W = 6;
  localparam int COS_W     = 16;
  localparam int PROD_W    = IN_W + COS_W;

  // pi in Q2.30
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // (2i+1)*(2i+2) for the ten Taylor terms of the cosine
  localparam logic [63:0] TAYLOR_DIV [10] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
    64'd132, 64'd182, 64'd240, 64'd306, 64'd380
  };

  // cos(x), x in Q2.30, as Q1.15 clamped to [0, 32767]; constant arguments only
  function automatic logic [COS_W-1:0] cos_q15(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = signed'(term);
    for (int i = 0; i < 10; i++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[i];
      if (i[0]) begin
        sum = sum + signed'(term);
      end else begin
        sum = sum - signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = (unsigned'(sum) + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[COS_W-1:0];
  endfunction

endpackage

/* hw/rtl/mdct_imdct_direct.sv */
// Throughput: one input word per cycle while loading with cfg_valid low, then the frame
// is computed by one shared MAC unit at one product per cycle within each sum (2N*N per frame).
// Reset: control cleared, direction forward, load count zero; frame store is not
// cleared (it is always fully written before it is read).
// ----------------------------------------------------------------------------
// mdct_imdct_direct
// Direct-form MDCT/IMDCT engine: loads a frame into a local store, then walks
// all output indexes with one multiply-accumulate unit and a cosine table.
// ----------------------------------------------------------------------------
module mdct_imdct_direct #(
  parameter int HALF_SIZE = mdct_pkg::HALF_SIZE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_direction,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [mdct_pkg::IN_W-1:0]     in_value,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mdct_pkg::OUT_W-1:0]    out_value,
  output logic [mdct_pkg::IDX_OUT_W-1:0]       out_index,
  output logic                                 out_last
);
  import mdct_pkg::*;

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int FRAME_MAX = 2 * HALF_SIZE;          // longest frame / store depth
  localparam int AW        = $clog2(FRAME_MAX);      // store address, counters
  localparam int ROM_N     = FRAME_MAX + 1;          // first-quadrant table size
  localparam int RI_W      = $clog2(ROM_N);
  localparam int PH_MOD    = 8 * HALF_SIZE;          // one full turn of the angle
  localparam int PH_W      = $clog2(PH_MOD);
  localparam int ACC_W     = PROD_W + AW;
  localparam int U_W       = 31;                     // magnitude for divide by N
  localparam int RECIP_SH  = 31;

  localparam logic [U_W-1:0]  RECIP   = U_W'((64'd1 << RECIP_SH) / HALF_SIZE);
  localparam logic [PH_W:0]   PH_FULL = (PH_W+1)'(PH_MOD);
  localparam logic [PH_W-1:0] PH_Q1   = PH_W'(2 * HALF_SIZE);
  localparam logic [PH_W-1:0] PH_Q2   = PH_W'(4 * HALF_SIZE);
  localparam logic [PH_W-1:0] PH_Q3   = PH_W'(6 * HALF_SIZE);

  // Angle index m = (2n+1+N)(2k+1) mod 8N is walked by additions only.
  localparam logic [PH_W-1:0] PH_INIT     = PH_W'(HALF_SIZE + 1);
  localparam logic [PH_W-1:0] FWD_DM0     = PH_W'(2);
  localparam logic [PH_W-1:0] INV_DM0     = PH_W'(2 * HALF_SIZE + 2);
  localparam logic [PH_W-1:0] FWD_M0_STEP = PH_W'(2 * HALF_SIZE + 2);
  localparam logic [PH_W-1:0] INV_M0_STEP = PH_W'(2);
  localparam logic [PH_W-1:0] DM_STEP     = PH_W'(4);

  localparam logic signed [ACC_W-1:0] FWD_RND = ACC_W'(2 ** 14);
  localparam logic signed [ACC_W-1:0] INV_RND = ACC_W'(HALF_SIZE * (2 ** 13));
  localparam logic signed [ACC_W-1:0] INV_BIAS = ACC_W'(HALF_SIZE - 1);

  // Sequencer states
  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_MAC   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_DIV1  = 3'd4;
  localparam logic [2:0] S_DIV2  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // add two angle indexes modulo 8N; both operands are already reduced
  function automatic logic [PH_W-1:0] ph_add(input logic [PH_W-1:0] a,
                                             input logic [PH_W-1:0] b);
    logic [PH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= PH_FULL) begin
      s = s - PH_FULL;
    end
    return s[PH_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Cosine table: cos(pi*r/(4N)), r = 0..2N, built at elaboration
  // --------------------------------------------------------------------------
  logic [COS_W-1:0] cos_rom [ROM_N];

  for (genvar r = 0; r < ROM_N; r++) begin : g_rom
    localparam logic [63:0] XR =
      (PI_Q30 * 64'(r) + 64'(2 * HALF_SIZE)) / 64'(4 * HALF_SIZE);
    assign cos_rom[r] = cos_q15(XR);
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [2:0]      state_r, state_nxt;
  logic            dir_r, dir_nxt;
  logic [AW-1:0]   load_cnt_r, load_cnt_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;            // output index being computed
  logic [AW-1:0]   j_r, j_nxt;                // product index within the sum
  logic [PH_W-1:0] m_r, m_nxt;                // angle of the current product
  logic [PH_W-1:0] m0_r, m0_nxt;              // angle of the first product
  logic [PH_W-1:0] dm_r, dm_nxt;              // angle step between products
  logic            p1_vld_r, p1_vld_nxt;
  logic            p2_vld_r;
  logic            out_valid_r, out_valid_nxt;

  logic signed [IN_W-1:0]   rd_data_r;
  logic signed [COS_W-1:0]  cos_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     neg_r;
  logic [U_W-1:0]           u_r;
  logic [U_W-1:0]           q0_r;
  logic signed [OUT_W-1:0]  res_r, res_nxt;
  logic signed [OUT_W-1:0]  out_value_r, out_value_nxt;
  logic [IDX_OUT_W-1:0]     out_index_r, out_index_nxt;
  logic                     out_last_r, out_last_nxt;

  logic signed [IN_W-1:0]   frame_mem [FRAME_MAX];

  // --------------------------------------------------------------------------
  // Frame-length decode
  // --------------------------------------------------------------------------
  logic [AW-1:0] in_last_idx;
  logic [AW-1:0] out_last_idx;

  assign in_last_idx  = dir_r ? AW'(HALF_SIZE - 1) : AW'(FRAME_MAX - 1);
  assign out_last_idx = dir_r ? AW'(FRAME_MAX - 1) : AW'(HALF_SIZE - 1);

  // --------------------------------------------------------------------------
  // Cosine lookup: fold the angle into the first quadrant, then apply sign
  // --------------------------------------------------------------------------
  logic [1:0]              quad;
  logic [PH_W-1:0]         ph_rem;
  logic [RI_W-1:0]         rom_idx;
  logic signed [COS_W-1:0] cos_mag;
  logic signed [COS_W-1:0] cos_val;

  always_comb begin
    if (m_r >= PH_Q3) begin
      quad   = 2'd3;
      ph_rem = m_r - PH_Q3;
    end else if (m_r >= PH_Q2) begin
      quad   = 2'd2;
      ph_rem = m_r - PH_Q2;
    end else if (m_r >= PH_Q1) begin
      quad   = 2'd1;
      ph_rem = m_r - PH_Q1;
    end else begin
      quad   = 2'd0;
      ph_rem = m_r;
    end
    // second and fourth quadrants read the table mirrored
    rom_idx = quad[0] ? RI_W'(PH_Q1 - ph_rem) : RI_W'(ph_rem);
    cos_mag = signed'(cos_rom[rom_idx]);
    // second and third quadrants are negative
    cos_val = (quad[0] ^ quad[1]) ? -cos_mag : cos_mag;
  end

  // --------------------------------------------------------------------------
  // Result rounding
  // --------------------------------------------------------------------------
  // Forward: floor((acc + 2^14) / 2^15), saturated to 32 bits.
  logic signed [ACC_W-1:0] fwd_full;
  logic                    fwd_ovf;
  logic signed [OUT_W-1:0] fwd_res;

  assign fwd_full = (acc_r + FWD_RND) >>> 15;
  assign fwd_ovf  = !((&fwd_full[ACC_W-1:OUT_W-1]) || !(|fwd_full[ACC_W-1:OUT_W-1]));
  always_comb begin
    if (fwd_ovf) begin
      fwd_res = fwd_full[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      fwd_res = fwd_full[OUT_W-1:0];
    end
  end

  // Inverse: floor((acc + N*2^13) / (N*2^14)) = floor(floor((acc + N*2^13)/2^14) / N).
  // Negative values divide their biased magnitude, then flip back.
  logic signed [ACC_W-1:0] inv_b;
  logic                    inv_neg;
  logic signed [ACC_W-1:0] inv_mag;
  logic [2*U_W-1:0]        recip_prod;
  logic [U_W-1:0]          div_rem;
  logic [U_W-1:0]          q_fix;
  logic signed [OUT_W-1:0] inv_res;

  assign inv_b      = (acc_r + INV_RND) >>> 14;
  assign inv_neg    = inv_b[ACC_W-1];
  assign inv_mag    = inv_neg ? (-inv_b + INV_BIAS) : inv_b;
  assign recip_prod = u_r * RECIP;
  // q0 is the true quotient or one short of it; one compare fixes it
  assign div_rem    = u_r - U_W'(q0_r * U_W'(HALF_SIZE));
  assign q_fix      = (div_rem >= U_W'(HALF_SIZE)) ? (q0_r + U_W'(1)) : q0_r;
  assign inv_res    = neg_r ? -signed'(OUT_W'(q_fix)) : signed'(OUT_W'(q_fix));

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic in_fire;
  logic cfg_fire;
  logic acc_clr;

  // a configuration word takes precedence over an input word
  assign cfg_ready = (state_r == S_LOAD);
  assign in_ready  = (state_r == S_LOAD) && !cfg_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_index = out_index_r;
  assign out_last  = out_last_r;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    dir_nxt       = dir_r;
    load_cnt_nxt  = load_cnt_r;
    idx_nxt       = idx_r;
    j_nxt         = j_r;
    m_nxt         = m_r;
    m0_nxt        = m0_r;
    dm_nxt        = dm_r;
    p1_vld_nxt    = 1'b0;
    acc_clr       = 1'b0;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_index_nxt = out_index_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_LOAD: begin
        if (cfg_fire) begin
          // new direction drops any partly loaded frame
          dir_nxt      = cfg_direction;
          load_cnt_nxt = '0;
        end else if (in_fire) begin
          if (load_cnt_r == in_last_idx) begin
            load_cnt_nxt = '0;
            idx_nxt      = '0;
            j_nxt        = '0;
            m0_nxt       = PH_INIT;
            m_nxt        = PH_INIT;
            dm_nxt       = dir_r ? INV_DM0 : FWD_DM0;
            acc_clr      = 1'b1;
            state_nxt    = S_MAC;
          end else begin
            load_cnt_nxt = load_cnt_r + AW'(1);
          end
        end
      end
      S_MAC: begin
        // issue one product per cycle
        p1_vld_nxt = 1'b1;
        j_nxt      = j_r + AW'(1);
        m_nxt      = ph_add(m_r, dm_r);
        if (j_r == in_last_idx) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!p1_vld_r && !p2_vld_r) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        if (dir_r) begin
          state_nxt = S_DIV1;
        end else begin
          res_nxt   = fwd_res;
          state_nxt = S_OUT;
        end
      end
      S_DIV1: begin
        state_nxt = S_DIV2;
      end
      S_DIV2: begin
        res_nxt   = inv_res;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          out_index_nxt = IDX_OUT_W'(idx_r);
          out_last_nxt  = (idx_r == out_last_idx);
          if (idx_r == out_last_idx) begin
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            j_nxt     = '0;
            m0_nxt    = ph_add(m0_r, dir_r ? INV_M0_STEP : FWD_M0_STEP);
            m_nxt     = m0_nxt;
            dm_nxt    = ph_add(dm_r, DM_STEP);
            acc_clr   = 1'b1;
            state_nxt = S_MAC;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      dir_r       <= 1'b0;
      load_cnt_r  <= '0;
      idx_r       <= '0;
      j_r         <= '0;
      p1_vld_r    <= 1'b0;
      p2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dir_r       <= dir_nxt;
      load_cnt_r  <= load_cnt_nxt;
      idx_r       <= idx_nxt;
      j_r         <= j_nxt;
      p1_vld_r    <= p1_vld_nxt;
      p2_vld_r    <= p1_vld_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath: frame store, MAC pipeline, divide steps, output register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      frame_mem[load_cnt_r] <= in_value;
    end
    rd_data_r <= frame_mem[j_r];
    cos_r     <= cos_val;
    prod_r    <= rd_data_r * cos_r;
    if (acc_clr) begin
      acc_r <= '0;
    end else if (p2_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (state_r == S_ROUND) begin
      neg_r <= inv_neg;
      u_r   <= inv_mag[U_W-1:0];
    end
    if (state_r == S_DIV1) begin
      q0_r <= recip_prod[RECIP_SH +: U_W];
    end
    m_r         <= m_nxt;
    m0_r        <= m0_nxt;
    dm_r        <= dm_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
    out_index_r <= out_index_nxt;
    out_last_r  <= out_last_nxt;
  end

`ifndef SYNTHESIS
  // no input word while products are still in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!p1_vld_r && !p2_vld_r))
    else $error("input accepted with MAC pipeline busy");

  // rounding only sees a fully drained accumulator
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (!p1_vld_r && !p2_vld_r))
    else $error("rounding started before MAC pipeline drained");

  // every MAC cycle feeds the pipeline
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |=> p1_vld_r)
    else $error("MAC cycle issued no product");

  // load counter stays inside the current frame
  assert property (@(posedge clk) disable iff (!rst_n)
    load_cnt_r <= in_last_idx)
    else $error("load counter beyond frame length");
`endif

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for mdct_imdct_direct. Loads forward frames of 2N
// samples and inverse frames of N coefficients, some frames cut short by a
// direction write. Each expected output frame is computed from a local cosine
// table and compared word by word. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mdct_pkg::*;

  localparam int N = HALF_SIZE_DEF;
  // worst frame latency (inverse) plus margin; also the quiet time before a
  // direction write when a partial frame may be sitting in the block
  localparam int SETTLE_CYCLES = 2 * N * (N + 7) + 100;

  localparam logic signed [IN_W-1:0] VAL_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] VAL_MIN = {1'b1, {(IN_W-1){1'b0}}};

  typedef enum logic {DIR_FORWARD = 1'b0, DIR_INVERSE = 1'b1} direction_t;
  typedef enum {STY_MIX, STY_MAX, STY_MIN, STY_ALT} frame_style_t;

  // --------------------------------------------------------------------------
  // Transform tracker: mirrors the frame store and load count, computes each
  // output frame when the last input word of a frame is accepted, and holds
  // the result words still to come.
  // --------------------------------------------------------------------------
  class transform_board;
    typedef struct {
      logic signed [OUT_W-1:0]  value;
      logic [IDX_OUT_W-1:0]     index;
      logic                     last;
    } result_t;

    result_t    pending_results[$];
    direction_t direction;
    longint     frame_store[2*N];
    int         load_count;
    int         cos_quarter[2*N+1];
    int         error_count;
    int         checked_count;

    function new();
      direction     = DIR_FORWARD;
      load_count    = 0;
      error_count   = 0;
      checked_count = 0;
      build_cos_quarter();
    endfunction

    // first quadrant of the cosine, Q1.15, from a truncating Taylor series
    function void build_cos_quarter();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned divisor;
      longint          series;
      longint          rounded;
      for (int r = 0; r <= 2 * N; r++) begin
        x      = (PI_Q30 * r + 2 * N) / (4 * N);
        x2     = (x * x) >> 30;
        term   = 64'd1 << 30;
        series = longint'(term);
        for (int i = 0; i < 10; i++) begin
          divisor = (2 * i + 1) * (2 * i + 2);
          term    = ((term * x2) >> 30) / divisor;
          if (i % 2 == 1) begin
            series += longint'(term);
          end else begin
            series -= longint'(term);
          end
        end
        if (series < 0) begin
          series = 0;
        end
        rounded = (series + 16384) / 32768;
        if (rounded > 32767) begin
          rounded = 32767;
        end
        cos_quarter[r] = int'(rounded);
      end
    endfunction

    function int cos_at(int unsigned m);
      int unsigned q;
      int unsigned r;
      m = m % (8 * N);
      q = m / (2 * N);
      r = m % (2 * N);
      case (q)
        0:       return cos_quarter[r];
        1:       return -cos_quarter[2*N-r];
        2:       return -cos_quarter[r];
        default: return cos_quarter[2*N-r];
      endcase
    endfunction

    function longint floor_div(longint a, longint d);
      if (a >= 0) begin
        return a / d;
      end
      return -((-a + d - 1) / d);
    endfunction

    function int frame_length();
      return (direction == DIR_INVERSE) ? N : 2 * N;
    endfunction

    function void transform_frame();
      int          out_len;
      longint      acc;
      longint      res;
      int unsigned n;
      int unsigned k;
      result_t     word;
      out_len = (direction == DIR_INVERSE) ? 2 * N : N;
      for (int i = 0; i < out_len; i++) begin
        acc = 0;
        for (int j = 0; j < frame_length(); j++) begin
          n = (direction == DIR_INVERSE) ? i : j;
          k = (direction == DIR_INVERSE) ? j : i;
          acc += frame_store[j] * cos_at((2 * n + 1 + N) * (2 * k + 1));
        end
        if (direction == DIR_INVERSE) begin
          res = floor_div(2 * acc + (longint'(N) << 14), longint'(N) << 15);
        end else begin
          res = floor_div(acc + 16384, 32768);
        end
        if (res > 64'sd2147483647) begin
          res = 64'sd2147483647;
        end
        if (res < -64'sd2147483648) begin
          res = -64'sd2147483648;
        end
        word.value = res[OUT_W-1:0];
        word.index = i[IDX_OUT_W-1:0];
        word.last  = (i == out_len - 1);
        pending_results.push_back(word);
      end
    endfunction

    // a direction write drops whatever part of a frame was loaded
    function void set_direction(direction_t d);
      direction  = d;
      load_count = 0;
    endfunction

    function void take_word(logic signed [IN_W-1:0] v);
      frame_store[load_count] = v;
      load_count++;
      if (load_count == frame_length()) begin
        transform_frame();
        load_count = 0;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report(string msg);
      $display("%0t ns MISMATCH: %s", $time, msg);
      error_count++;
    endtask

    task check_result(logic signed [OUT_W-1:0] value, logic [IDX_OUT_W-1:0] index,
                      logic last);
      result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result word with none expected: value %0d index %0d",
                         value, index));
        return;
      end
      want = pending_results.pop_front();
      checked_count++;
      if (value !== want.value) begin
        report($sformatf("index %0d: value %0d, want %0d", want.index, value,
                         want.value));
      end
      if (index !== want.index) begin
        report($sformatf("index %0d, want %0d", index, want.index));
      end
      if (last !== want.last) begin
        report($sformatf("index %0d: last %0b, want %0b", want.index, last,
                         want.last));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and its signals
  // --------------------------------------------------------------------------
  logic                     clk;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic                     cfg_direction;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [IN_W-1:0]   in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [OUT_W-1:0]  out_value;
  logic [IDX_OUT_W-1:0]     out_index;
  logic                     out_last;

  mdct_imdct_direct #(
    .HALF_SIZE(N)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_direction (cfg_direction),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_index     (out_index),
    .out_last      (out_last)
  );

  transform_board board = new();

  // idle odds in percent for each side; changed between phases
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int words_sent    = 0;
  int forward_frames = 0;
  int inverse_frames = 0;

  // short directed opener: field extremes and bit patterns, left as a
  // partial forward frame that the next direction write must drop
  logic signed [IN_W-1:0] directed_words [12] = '{
    VAL_MAX, VAL_MIN, 24'sd0, -24'sd1, 24'sd1, 24'h555555,
    24'hAAAAAA, 24'sd32768, -24'sd32768, 24'h00FF00, 24'hFF00FF, VAL_MAX
  };

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Write the direction register; only called while the block is idle.
  task automatic write_direction(direction_t d);
    cfg_valid     <= 1'b1;
    cfg_direction <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_direction(d);
  endtask

  // Offer one input word, with a random gap first; hold valid and payload
  // until accepted. Valid stays high on return so back-to-back words run
  // without a bubble.
  task automatic send_word(logic signed [IN_W-1:0] v);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    board.take_word(v);
    words_sent++;
  endtask

  // Drop valid, hold until every expected word has come, then idle a while.
  task automatic wait_for_results(int extra_cycles);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  function automatic logic signed [IN_W-1:0] pick_value(frame_style_t style, int pos);
    case (style)
      STY_MAX: return VAL_MAX;
      STY_MIN: return VAL_MIN;
      STY_ALT: return (pos % 2 == 1) ? VAL_MIN : VAL_MAX;
      default: begin
        case ($urandom_range(0, 9))
          0:       return VAL_MAX;
          1:       return VAL_MIN;
          2:       return ($urandom_range(0, 1) == 1) ? 24'sd0 : -24'sd1;
          3:       return $signed(24'($urandom_range(0, 65535))) - 24'sd32768;
          default: return 24'($urandom);
        endcase
      end
    endcase
  endfunction

  // One phase: settle, pick idle odds, write the direction, load whole frames
  // (pausing for all results between frames) and then a partial tail that the
  // next phase's direction write drops.
  task automatic run_phase(int send_pct, int recv_pct, direction_t d, int n_frames,
                           frame_style_t first_style, int tail_words);
    wait_for_results(SETTLE_CYCLES);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_direction(d);
    for (int f = 0; f < n_frames; f++) begin
      if (f > 0) begin
        wait_for_results(0);
      end
      for (int p = 0; p < ((d == DIR_INVERSE) ? N : 2 * N); p++) begin
        send_word(pick_value((f == 0) ? first_style : STY_MIX, p));
      end
      if (d == DIR_INVERSE) begin
        inverse_frames++;
      end else begin
        forward_frames++;
      end
    end
    for (int p = 0; p < tail_words; p++) begin
      send_word(pick_value(STY_MIX, p));
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: check each accepted word, then toss ready for the next edge
  // --------------------------------------------------------------------------
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        board.check_result(out_value, out_index, out_last);
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    in_valid      <= 1'b0;
    in_value      <= '0;
    cfg_valid     <= 1'b0;
    cfg_direction <= 1'b0;
    rst_n         <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed opener under the first idle mix
    send_idle_pct = 24;
    recv_idle_pct = 77;
    write_direction(DIR_FORWARD);
    foreach (directed_words[i]) begin
      send_word(directed_words[i]);
    end

    // sender idles lightly, receiver heavily
    run_phase(24, 77, DIR_INVERSE, 1, STY_MAX, 10);
    run_phase(24, 77, DIR_FORWARD, 1, STY_MIN, 0);
    // the other way round
    run_phase(77, 24, DIR_FORWARD, 1, STY_MIX, 6);
    run_phase(77, 24, DIR_INVERSE, 1, STY_ALT, 0);
    // full rate on both sides
    run_phase(0, 0, DIR_FORWARD, 1, STY_MAX, 0);
    run_phase(0, 0, DIR_INVERSE, 1, STY_MIN, 0);

    // drain and give any stray word time to show up
    wait_for_results(SETTLE_CYCLES);

    $display("Summary: %0d input words, %0d forward and %0d inverse frames, %0d result words",
             words_sent, forward_frames, inverse_frames, board.checked_count);
    $display("Summary: partial frames dropped by direction writes, stalls on both sides");
    if (board.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Watchdog: far beyond the slowest legal run
  // --------------------------------------------------------------------------
  initial begin
    #5_000_000;
    $display("Timeout with %0d result words outstanding", board.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* mdct_imdct_direct.f */
hw/rtl/mdct_pkg.sv
hw/rtl/mdct_imdct_direct.sv
tb/sv/testbench.sv
